>>> rtl/text_console_writer_defines.svh
// ----------------------------------------------------------------------------
// text_console_writer_defines
// Assertion macros shared by the console RTL.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int MAX_COLUMNS = 80;
  localparam int MAX_ROWS    = 25;
  localparam int CELL_COUNT  = MAX_COLUMNS * MAX_ROWS;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ADDR_W = 11;
  localparam int CELL_W = 16;
  localparam int PROD_W = COL_W + ROW_W;

  localparam logic [COL_W-1:0]  COL_MAX   = COL_W'(MAX_COLUMNS);
  localparam logic [ROW_W-1:0]  ROW_MAX   = ROW_W'(MAX_ROWS);
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELL_COUNT - 1);

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;
  localparam logic [CELL_W-1:0] TEXT_ATTR  = 16'h0F00;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    K_PUT,
    K_BKSP,
    K_NEWLINE,
    K_RETURN,
    K_NUL,
    K_CLEAR,
    K_READ,
    K_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [7:0]         char_code;
    logic [ADDR_W-1:0]  cell_address;
  } cmd_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RDWAIT,
    S_CURSOR,
    S_MUL,
    S_WRITE,
    S_SCR_SETUP,
    S_SCR_RD,
    S_SCR_WR,
    S_SCR_BLANK,
    S_DONE
  } eng_state_t;

endpackage

>>> rtl/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front
// Input side: takes stream transfers and decodes them into commands.
// ----------------------------------------------------------------------------
module tcw_front (
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [23:0]   s_tdata,   // char_code[7:0], cell_address[18:8]
  input  logic [1:0]    s_tuser,   // opcode[1:0]
  input  logic          q_full,
  input  logic          init_busy,
  output logic          push,
  output tcw_pkg::cmd_t cmd
);
  import tcw_pkg::*;

  logic [7:0] ch;

  assign ch       = s_tdata[7:0];
  assign s_tready = !q_full && !init_busy;
  assign push     = s_tvalid && s_tready;

  always_comb begin
    cmd.char_code    = ch;
    cmd.cell_address = s_tdata[18:8];
    case (opcode_t'(s_tuser))
      OP_PUT: begin
        case (ch)
          CH_NUL:  cmd.kind = K_NUL;
          CH_BS:   cmd.kind = K_BKSP;
          CH_LF:   cmd.kind = K_NEWLINE;
          CH_CR:   cmd.kind = K_RETURN;
          default: cmd.kind = K_PUT;
        endcase
      end
      OP_CLEAR: cmd.kind = K_CLEAR;
      OP_READ:  cmd.kind = K_READ;
      default:  cmd.kind = K_NOP;
    endcase
  end

endmodule

>>> rtl/tcw_queue.sv
// ----------------------------------------------------------------------------
// tcw_queue
// Two-entry command queue between the decoder and the engine.
// ----------------------------------------------------------------------------
module tcw_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tcw_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output tcw_pkg::cmd_t head
);
  import tcw_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

endmodule

>>> rtl/tcw_engine.sv
// ----------------------------------------------------------------------------
// tcw_engine
// Back end: screen store, cursor, scroll and clear sweeps, result register.
// ----------------------------------------------------------------------------
module tcw_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  input  logic          cfg_index,
  input  logic [6:0]    cfg_data,
  input  logic          q_valid,
  input  tcw_pkg::cmd_t q_head,
  output logic          q_pop,
  output logic          init_busy,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [31:0]   m_tdata
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CELL_W-1:0] wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;
  logic [CELL_W-1:0] rdata;

  logic [COL_W-1:0]  screen_columns;
  logic [ROW_W-1:0]  screen_rows;
  logic [COL_W-1:0]  cols;
  logic [ROW_W-1:0]  rows;

  eng_state_t        state, state_next;
  logic [COL_W-1:0]  col, col_next;
  logic [ROW_W-1:0]  line, line_next;
  logic [ADDR_W-1:0] idx, idx_next;
  logic [COL_W-1:0]  bcnt, bcnt_next;
  logic [ADDR_W-1:0] base, base_next;
  cmd_t              cur, cur_next;
  logic [CELL_W-1:0] val, val_next;
  logic              init_next;
  logic              load_out;

  logic [COL_W-1:0]  ncol;
  logic [ROW_W-1:0]  nline;
  logic [ROW_W-1:0]  lplus;
  logic [PROD_W-1:0] prod;

  assign cols = (screen_columns == '0) ? COL_W'(1) :
                (screen_columns > COL_MAX) ? COL_MAX : screen_columns;
  assign rows = (screen_rows == '0) ? ROW_W'(1) :
                (screen_rows > ROW_MAX) ? ROW_MAX : screen_rows;

  assign ncol  = (col > cols) ? cols : col;
  assign nline = (line >= rows) ? rows - ROW_W'(1) : line;
  assign lplus = nline + ROW_W'(1);
  assign prod  = {{COL_W{1'b0}}, line} * {{ROW_W{1'b0}}, cols};

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_columns <= COL_MAX;
      screen_rows    <= ROW_MAX;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COLUMNS: screen_columns <= cfg_data;
        REG_ROWS:    screen_rows    <= cfg_data[ROW_W-1:0];
        default:     screen_rows    <= screen_rows;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      init_busy <= 1'b1;
      idx       <= '0;
      col       <= '0;
      line      <= '0;
    end else begin
      state     <= state_next;
      init_busy <= init_next;
      idx       <= idx_next;
      col       <= col_next;
      line      <= line_next;
    end
  end

  always_ff @(posedge clk) begin
    bcnt <= bcnt_next;
    base <= base_next;
    cur  <= cur_next;
    val  <= val_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) m_tdata <= {4'b0, val, line, col};
  end

  always_comb begin
    state_next = state;
    init_next  = init_busy;
    idx_next   = idx;
    col_next   = col;
    line_next  = line;
    bcnt_next  = bcnt;
    base_next  = base;
    cur_next   = cur;
    val_next   = val;
    q_pop      = 1'b0;
    we         = 1'b0;
    waddr      = idx;
    wdata      = BLANK_CELL;
    re         = 1'b0;
    raddr      = cur.cell_address;
    load_out   = 1'b0;
    case (state)
      S_CLEAR: begin
        we = 1'b1;
        if (idx == LAST_CELL) begin
          idx_next  = '0;
          col_next  = '0;
          line_next = '0;
          val_next  = '0;
          if (init_busy) begin
            init_next  = 1'b0;
            state_next = S_IDLE;
          end else begin
            state_next = S_DONE;
          end
        end else begin
          idx_next = idx + ADDR_W'(1);
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          cur_next = q_head;
          val_next = '0;
          case (q_head.kind)
            K_CLEAR: begin
              idx_next   = '0;
              state_next = S_CLEAR;
            end
            K_READ: begin
              if (q_head.cell_address <= LAST_CELL) begin
                re         = 1'b1;
                raddr      = q_head.cell_address;
                state_next = S_RDWAIT;
              end else begin
                state_next = S_DONE;
              end
            end
            K_NOP:   state_next = S_DONE;
            default: state_next = S_CURSOR;
          endcase
        end
      end
      S_RDWAIT: begin
        val_next   = rdata;
        state_next = S_DONE;
      end
      S_CURSOR: begin
        case (cur.kind)
          K_NUL: begin
            col_next   = ncol;
            line_next  = nline;
            state_next = S_DONE;
          end
          K_RETURN: begin
            col_next   = '0;
            line_next  = nline;
            state_next = S_DONE;
          end
          K_BKSP: begin
            line_next = nline;
            if (ncol != '0) begin
              col_next   = ncol - COL_W'(1);
              state_next = S_MUL;
            end else begin
              col_next   = ncol;
              state_next = S_DONE;
            end
          end
          K_NEWLINE: begin
            col_next = '0;
            if (lplus >= rows) begin
              line_next  = rows - ROW_W'(1);
              state_next = S_SCR_SETUP;
            end else begin
              line_next  = lplus;
              state_next = S_DONE;
            end
          end
          default: begin
            if (ncol >= cols) begin
              col_next = '0;
              if (lplus >= rows) begin
                line_next  = rows - ROW_W'(1);
                state_next = S_SCR_SETUP;
              end else begin
                line_next  = lplus;
                state_next = S_MUL;
              end
            end else begin
              col_next   = ncol;
              line_next  = nline;
              state_next = S_MUL;
            end
          end
        endcase
      end
      S_MUL: begin
        base_next  = prod[ADDR_W-1:0];
        state_next = S_WRITE;
      end
      S_WRITE: begin
        we    = 1'b1;
        waddr = base + {{(ADDR_W-COL_W){1'b0}}, col};
        if (cur.kind == K_BKSP) begin
          wdata = BLANK_CELL;
        end else begin
          wdata    = TEXT_ATTR | {8'h00, cur.char_code};
          col_next = col + COL_W'(1);
        end
        state_next = S_DONE;
      end
      S_SCR_SETUP: begin
        base_next  = prod[ADDR_W-1:0];
        idx_next   = '0;
        bcnt_next  = '0;
        state_next = S_SCR_RD;
      end
      S_SCR_RD: begin
        if (idx < base) begin
          re         = 1'b1;
          raddr      = idx + {{(ADDR_W-COL_W){1'b0}}, cols};
          state_next = S_SCR_WR;
        end else begin
          state_next = S_SCR_BLANK;
        end
      end
      S_SCR_WR: begin
        we         = 1'b1;
        wdata      = rdata;
        idx_next   = idx + ADDR_W'(1);
        state_next = S_SCR_RD;
      end
      S_SCR_BLANK: begin
        we       = 1'b1;
        idx_next = idx + ADDR_W'(1);
        if (bcnt == cols - COL_W'(1)) begin
          state_next = (cur.kind == K_PUT) ? S_MUL : S_DONE;
        end else begin
          bcnt_next = bcnt + COL_W'(1);
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> rtl/text_console_writer.sv
// Path: an input transfer is decoded and queued, the engine pops and works it,
//   and its result is registered; the engine's store port sets the pace.
// Scroll copies each row up and blanks the last row; clear walks 2000 cells, one a cycle.
// One item is worked at a time; up to two more wait in the command queue.
// Reset (rst, synchronous): cursor home, registers 80 x 25, then a blanking pass
//   of all 2000 cells of the store with s_tready low; config writes still taken.
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console: decoder, command queue and screen engine.
// ----------------------------------------------------------------------------
`include "text_console_writer_defines.svh"

module text_console_writer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // char_code[7:0], cell_address[18:8]
  input  logic [1:0]  s_tuser,   // opcode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // cursor_column[6:0], cursor_row[11:7], cell_value[27:12]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);
  import tcw_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_valid;
  logic q_pop;
  cmd_t q_head;
  logic init_busy;

  assign cfg_ready = 1'b1;

  tcw_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_full    (q_full),
    .init_busy (init_busy),
    .push      (push),
    .cmd       (push_cmd)
  );

  tcw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  tcw_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  `TCW_ASSERT_NOW(a_init_no_result, $fell(init_busy), !m_tvalid, "result during init pass")
  `TCW_ASSERT_NEXT(a_accept_queued, s_tvalid && s_tready, q_valid, "accepted item not queued")
  `TCW_ASSERT_NOW(a_cursor_range, m_tvalid, (m_tdata[6:0] <= COL_MAX) && (m_tdata[11:7] < ROW_MAX), "cursor out of range")

endmodule
